[rtl/stepper_phase_sequencer_assert.svh]
// assertion macros for the stepper phase sequencer checker
// expects clk and rst_n in the scope where a macro is used
`ifndef STEPPER_PHASE_SEQUENCER_ASSERT_SVH
`define STEPPER_PHASE_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define SPSEQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spseq check failed");

// next-cycle implication
`define SPSEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spseq check failed");

`endif

[rtl/spseq_pkg.sv]
// shared types, codes and coil tables of the stepper phase sequencer
// no dependencies
package spseq_pkg;

  localparam int COUNT_W  = 16;
  localparam int BUDGET_W = 16;
  localparam int CMP_W    = (COUNT_W > BUDGET_W) ? COUNT_W : BUDGET_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // operation codes
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_START_CCW = 3'd1;
  localparam logic [2:0] OP_START_CW  = 3'd2;
  localparam logic [2:0] OP_STOP      = 3'd3;
  localparam logic [2:0] OP_SAMPLE    = 3'd4;

  // stop causes
  localparam logic [1:0] CAUSE_NONE  = 2'd0;
  localparam logic [1:0] CAUSE_DONE  = 2'd1;
  localparam logic [1:0] CAUSE_FAULT = 2'd2;
  localparam logic [1:0] CAUSE_OVERC = 2'd3;

  // step modes
  localparam logic [1:0] MODE_FULL      = 2'd0;
  localparam logic [1:0] MODE_HALF_FAST = 2'd1;
  localparam logic [1:0] MODE_HALF_SLOW = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OC_LIMIT  = 2'd2;

  // register reset values
  localparam logic [1:0]  RST_STEP_MODE = MODE_HALF_FAST;
  localparam logic [14:0] RST_STEPS     = 15'd400;
  localparam logic [11:0] RST_OC_LIMIT  = 12'd1500;

  typedef struct packed {
    logic [2:0]  operation;
    logic [11:0] current_sample;
  } in_word_t;

  typedef struct packed {
    logic       a_out1;
    logic       a_out2;
    logic       b_out1;
    logic       b_out2;
    logic       driver_enable;
    logic       running;
    logic       clockwise;
    logic [1:0] stop_cause;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  step_mode;
    logic [14:0] steps_per_action;
    logic [11:0] over_current_limit;
  } cfg_t;

  // coil pattern {A1,A2,B1,B2} for a mode and phase index
  function automatic logic [3:0] coil_lookup(input logic [1:0] mode,
                                             input logic [2:0] idx);
    logic [3:0] pat;
    pat = 4'h0;
    case (mode)
      MODE_HALF_FAST: begin
        case (idx)
          3'd0: pat = 4'h1;
          3'd1: pat = 4'h9;
          3'd2: pat = 4'h8;
          3'd3: pat = 4'hA;
          3'd4: pat = 4'h2;
          3'd5: pat = 4'h6;
          3'd6: pat = 4'h4;
          default: pat = 4'h5;
        endcase
      end
      MODE_HALF_SLOW: begin
        case (idx)
          3'd0: pat = 4'hD;
          3'd1: pat = 4'h9;
          3'd2: pat = 4'hB;
          3'd3: pat = 4'hA;
          3'd4: pat = 4'hE;
          3'd5: pat = 4'h6;
          3'd6: pat = 4'h7;
          default: pat = 4'h5;
        endcase
      end
      default: begin
        case (idx[1:0])
          2'd0: pat = 4'h9;
          2'd1: pat = 4'hA;
          2'd2: pat = 4'h6;
          default: pat = 4'h5;
        endcase
      end
    endcase
    return pat;
  endfunction

endpackage

[rtl/spseq_cfg_regs.sv]
// configuration registers of the stepper phase sequencer
// depends on spseq_pkg
module spseq_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [spseq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spseq_pkg::CFG_DATA_W-1:0] cfg_data,
  output spseq_pkg::cfg_t                  cfg
);

  spseq_pkg::cfg_t cfg_r;
  spseq_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        spseq_pkg::REG_STEP_MODE: cfg_nxt.step_mode          = cfg_data[1:0];
        spseq_pkg::REG_STEPS:     cfg_nxt.steps_per_action   = cfg_data[14:0];
        spseq_pkg::REG_OC_LIMIT:  cfg_nxt.over_current_limit = cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_mode          <= spseq_pkg::RST_STEP_MODE;
      cfg_r.steps_per_action   <= spseq_pkg::RST_STEPS;
      cfg_r.over_current_limit <= spseq_pkg::RST_OC_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/spseq_core.sv]
// motor state and per-word update of the stepper phase sequencer
// depends on spseq_pkg
module spseq_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  spseq_pkg::in_word_t  word,
  input  spseq_pkg::cfg_t      cfg,
  output spseq_pkg::out_word_t result
);

  localparam logic [spseq_pkg::COUNT_W-1:0] CNT_MAX = '1;

  logic [2:0]                    phase_r, phase_nxt;
  logic [spseq_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  logic                          active_r, active_nxt;
  logic                          cw_r, cw_nxt;
  logic [3:0]                    coil_r, coil_nxt;
  logic [1:0]                    cause;

  logic                           half;
  logic [spseq_pkg::BUDGET_W-1:0] budget;
  logic [spseq_pkg::COUNT_W-1:0]  cnt_inc;
  logic                           keep_going;
  logic [2:0]                     phase_adv;

  always_comb begin
    half   = (cfg.step_mode == spseq_pkg::MODE_HALF_FAST) ||
             (cfg.step_mode == spseq_pkg::MODE_HALF_SLOW);
    budget = half ? {cfg.steps_per_action, 1'b0} : {1'b0, cfg.steps_per_action};
    // saturating step count
    cnt_inc = (cnt_r != CNT_MAX) ? cnt_r + 1'b1 : cnt_r;
    keep_going = (spseq_pkg::CMP_W'(cnt_inc) < spseq_pkg::CMP_W'(budget)) &&
                 (cnt_inc != CNT_MAX);
    // wrap modulo 8 in half step, modulo 4 otherwise
    if (half)
      phase_adv = cw_r ? phase_r + 3'd1 : phase_r - 3'd1;
    else
      phase_adv = {1'b0, cw_r ? phase_r[1:0] + 2'd1 : phase_r[1:0] - 2'd1};

    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    active_nxt = active_r;
    cw_nxt     = cw_r;
    coil_nxt   = coil_r;
    cause      = spseq_pkg::CAUSE_NONE;

    case (word.operation)
      spseq_pkg::OP_TICK: begin
        if (active_r) begin
          cnt_nxt = cnt_inc;
          if (keep_going) begin
            phase_nxt = phase_adv;
            coil_nxt  = spseq_pkg::coil_lookup(cfg.step_mode, phase_adv);
          end else begin
            active_nxt = 1'b0;
            coil_nxt   = 4'h0;
            cause      = spseq_pkg::CAUSE_DONE;
          end
        end
      end
      spseq_pkg::OP_START_CCW, spseq_pkg::OP_START_CW: begin
        if (!active_r) begin
          active_nxt = 1'b1;
          cw_nxt     = (word.operation == spseq_pkg::OP_START_CW);
          cnt_nxt    = '0;
        end
      end
      spseq_pkg::OP_STOP: begin
        if (active_r) begin
          active_nxt = 1'b0;
          coil_nxt   = 4'h0;
          cause      = spseq_pkg::CAUSE_FAULT;
        end
      end
      spseq_pkg::OP_SAMPLE: begin
        if (active_r && (word.current_sample > cfg.over_current_limit)) begin
          active_nxt = 1'b0;
          coil_nxt   = 4'h0;
          cause      = spseq_pkg::CAUSE_OVERC;
        end
      end
      default: ;
    endcase

    result.a_out1        = coil_nxt[3];
    result.a_out2        = coil_nxt[2];
    result.b_out1        = coil_nxt[1];
    result.b_out2        = coil_nxt[0];
    result.driver_enable = active_nxt;
    result.running       = active_nxt;
    result.clockwise     = cw_nxt;
    result.stop_cause    = cause;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      cnt_r    <= '0;
      active_r <= 1'b0;
      cw_r     <= 1'b0;
      coil_r   <= 4'h0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      active_r <= active_nxt;
      cw_r     <= cw_nxt;
      coil_r   <= coil_nxt;
    end
  end

endmodule

[rtl/stepper_phase_sequencer.sv]
// top level of the stepper phase sequencer: input register, core, result register
// depends on spseq_pkg, spseq_cfg_regs and spseq_core
//
// Stepper phase sequencer. Takes one word per clock while in_stall is low:
// tick, start (either direction), fault stop or current sample, and returns
// exactly one result word per input word showing coil drive levels, driver
// enable, running, direction and the stop cause of that word. Each word passes
// an input register, is resolved against the motor state in short logic (one
// 16-bit count compare, one 12-bit current compare, a small coil table) and
// lands in a result register, so the sustained rate is one word per cycle
// while out_stall is low. The result register is refilled in the cycle its
// word is taken, so the input keeps flowing while the sink takes words back
// to back; in_stall rises only when both registers hold words and out_stall
// is high. Configuration writes are always ready and take effect at the next
// word; write them only while the block is idle.
module stepper_phase_sequencer (
  input  logic                             clk,
  input  logic                             rst_n,
  // input words
  input  logic                             in_valid,
  output logic                             in_stall,
  input  spseq_pkg::in_word_t              in_word,
  // result words
  output logic                             out_valid,
  input  logic                             out_stall,
  output spseq_pkg::out_word_t             out_word,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [spseq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spseq_pkg::CFG_DATA_W-1:0] cfg_data
);

  spseq_pkg::cfg_t      cfg;
  spseq_pkg::in_word_t  in_word_r;
  logic                 in_valid_r, in_valid_nxt;
  spseq_pkg::out_word_t out_word_r;
  logic                 out_valid_r;
  spseq_pkg::out_word_t result;
  logic                 out_adv;
  logic                 fire;
  logic                 in_take;

  // result register can load when empty or being drained this cycle
  assign out_adv  = !out_valid_r || !out_stall;
  // held word is resolved and moves to the result register
  assign fire     = in_valid_r && out_adv;
  assign in_stall = in_valid_r && !out_adv;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take)
      in_valid_nxt = 1'b1;
    else if (fire)
      in_valid_nxt = 1'b0;
  end

  spseq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  spseq_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .word   (in_word_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
      if (out_adv) begin
        out_valid_r <= fire;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r <= in_word;
    end
    if (fire) begin
      out_word_r <= result;
    end
  end

endmodule

[rtl/spseq_checker.sv]
// port-level checks for the stepper phase sequencer, bound to the top level
// depends on spseq_pkg and stepper_phase_sequencer_assert.svh
`include "stepper_phase_sequencer_assert.svh"

module spseq_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input spseq_pkg::out_word_t out_word
);

  // a stalled result word holds
  `SPSEQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

  // driver is awake exactly while running
  `SPSEQ_ASSERT_NOW(a_enable_run, out_valid, out_word.driver_enable == out_word.running)

  // a word that stops the motor leaves it idle
  `SPSEQ_ASSERT_NOW(a_stop_idle, out_valid && (out_word.stop_cause != spseq_pkg::CAUSE_NONE), !out_word.running)

  // coils are off whenever idle
  `SPSEQ_ASSERT_NOW(a_idle_coils, out_valid && !out_word.running, !out_word.a_out1 && !out_word.a_out2 && !out_word.b_out1 && !out_word.b_out2)

endmodule

bind stepper_phase_sequencer spseq_checker u_spseq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
